// File: sv/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the packet rule classifier
// Transaction structs, rule storage layout and protocol codes used by the
// rule cells, the result emitter and the top level.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int RULE_SLOTS = 16;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_CHECK = 1'b1;

	localparam logic [2:0] PROTO_TCP = 3'd0;
	localparam logic [2:0] PROTO_UDP = 3'd1;
	localparam logic [2:0] PROTO_ANY = 3'd4;

	localparam logic [1:0] KIND_V4 = 2'd0;
	localparam logic [1:0] KIND_V6 = 2'd1;

	localparam logic [7:0] FLAGS_ANY = 8'hFF;

	// rule_opts bit positions
	localparam int OPT_SRC_ADDR_ANY = 0;
	localparam int OPT_SRC_PORT_ANY = 1;
	localparam int OPT_DST_ADDR_ANY = 2;
	localparam int OPT_DST_PORT_ANY = 3;
	localparam int OPT_ACTION_LOG   = 4;

	// input transaction
	typedef struct packed {
		logic        mode;
		logic [3:0]  slot;
		logic [2:0]  proto_code;
		logic [1:0]  net_kind;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [15:0] src_port_num;
		logic [15:0] dst_port_num;
		logic [7:0]  tcp_flag_bits;
		logic [4:0]  rule_opts;
	} item_t;

	// result transaction
	typedef struct packed {
		logic [3:0] hit_slot;
		logic       action_kind;
		logic       hit;
		logic       last;
	} result_t;

	// packet header fields that travel down the cell chain
	typedef struct packed {
		logic [2:0]  proto;
		logic [1:0]  kind;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  flags;
	} probe_t;

	// one stored rule
	typedef struct packed {
		logic [2:0]  proto;
		logic        v6;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  flags;
		logic [4:0]  opts;
	} rule_t;

	// link between neighboring cells; match and action bits shift right
	typedef struct packed {
		logic                  vld;
		probe_t                probe;
		logic [RULE_SLOTS-1:0] hits;
		logic [RULE_SLOTS-1:0] acts;
	} link_t;

endpackage

// File: sv/prc_cell.sv
// ----------------------------------------------------------------------------
// prc_cell: one rule slot of the classifier chain
// Holds one rule, compares it against the packet passing by and hands the
// packet, with its match and action bits shifted in, to the next cell.
// ----------------------------------------------------------------------------
module prc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ld_en,
	input  prc_pkg::item_t  ld,
	input  prc_pkg::link_t  up,
	output prc_pkg::link_t  dn
);

	prc_pkg::rule_t rule_q;
	logic           valid_q;
	logic           dn_vld_q;
	prc_pkg::probe_t dn_probe_q;
	logic [prc_pkg::RULE_SLOTS-1:0] dn_hits_q;
	logic [prc_pkg::RULE_SLOTS-1:0] dn_acts_q;

	logic proto_ok, src_ok, dst_ok, sport_ok, dport_ok, flags_ok, l4_ports, match;

	function automatic logic addr_ok(input logic any, input logic v6, input logic [1:0] kind,
		input logic [63:0] rhi, input logic [63:0] rlo,
		input logic [63:0] phi, input logic [63:0] plo);
		logic ok;
		ok = any;
		if (kind == prc_pkg::KIND_V4 && !v6 && rlo[31:0] == plo[31:0])
			ok = 1'b1;
		if (kind == prc_pkg::KIND_V6 && v6 && rhi == phi && rlo == plo)
			ok = 1'b1;
		return ok;
	endfunction

	// capture the rule on a load
	always_ff @(posedge clk) begin
		if (ld_en) begin
			rule_q.proto  <= ld.proto_code;
			rule_q.v6     <= (ld.net_kind == prc_pkg::KIND_V6);
			rule_q.src_hi <= ld.src_addr_hi;
			rule_q.src_lo <= ld.src_addr_lo;
			rule_q.dst_hi <= ld.dst_addr_hi;
			rule_q.dst_lo <= ld.dst_addr_lo;
			rule_q.sport  <= ld.src_port_num;
			rule_q.dport  <= ld.dst_port_num;
			rule_q.flags  <= ld.tcp_flag_bits;
			rule_q.opts   <= ld.rule_opts;
		end
	end

	// mark the slot valid once loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld_en) begin
			valid_q <= 1'b1;
		end
	end

	// compare rule against the passing packet
	always_comb begin
		l4_ports = (up.probe.proto == prc_pkg::PROTO_TCP) ||
			(up.probe.proto == prc_pkg::PROTO_UDP);
		proto_ok = (rule_q.proto == up.probe.proto) || (rule_q.proto == prc_pkg::PROTO_ANY);
		src_ok   = addr_ok(rule_q.opts[prc_pkg::OPT_SRC_ADDR_ANY], rule_q.v6, up.probe.kind,
			rule_q.src_hi, rule_q.src_lo, up.probe.src_hi, up.probe.src_lo);
		dst_ok   = addr_ok(rule_q.opts[prc_pkg::OPT_DST_ADDR_ANY], rule_q.v6, up.probe.kind,
			rule_q.dst_hi, rule_q.dst_lo, up.probe.dst_hi, up.probe.dst_lo);
		sport_ok = rule_q.opts[prc_pkg::OPT_SRC_PORT_ANY] ||
			(l4_ports && rule_q.sport == up.probe.sport);
		dport_ok = rule_q.opts[prc_pkg::OPT_DST_PORT_ANY] ||
			(l4_ports && rule_q.dport == up.probe.dport);
		flags_ok = (rule_q.flags == prc_pkg::FLAGS_ANY) ||
			(rule_q.flags == up.probe.flags && rule_q.proto == prc_pkg::PROTO_TCP);
		match    = valid_q && proto_ok && src_ok && dst_ok && sport_ok && dport_ok && flags_ok;
	end

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_vld_q <= 1'b0;
		end else begin
			dn_vld_q <= up.vld;
		end
	end

	// advance the packet and shift in this slot's result
	always_ff @(posedge clk) begin
		dn_probe_q <= up.probe;
		dn_hits_q  <= {match, up.hits[prc_pkg::RULE_SLOTS-1:1]};
		dn_acts_q  <= {rule_q.opts[prc_pkg::OPT_ACTION_LOG], up.acts[prc_pkg::RULE_SLOTS-1:1]};
	end

	assign dn.vld   = dn_vld_q;
	assign dn.probe = dn_probe_q;
	assign dn.hits  = dn_hits_q;
	assign dn.acts  = dn_acts_q;

endmodule

// File: sv/prc_emit.sv
// ----------------------------------------------------------------------------
// prc_emit: result emitter
// Takes the match vector at the end of the chain and hands out one result
// per matching slot in slot order, or a single no-hit result.
// ----------------------------------------------------------------------------
module prc_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  prc_pkg::link_t   tail,
	output logic             result_valid,
	input  logic             result_stall,
	output prc_pkg::result_t result,
	output logic             done
);

	logic [prc_pkg::RULE_SLOTS-1:0] hits_q;
	logic [prc_pkg::RULE_SLOTS-1:0] acts_q;
	logic                           busy_q;
	logic [prc_pkg::RULE_SLOTS-1:0] rest;
	logic [3:0]                     idx;
	logic                           act;
	logic                           take;

	// find the lowest pending slot
	always_comb begin
		idx = '0;
		act = 1'b0;
		for (int i = prc_pkg::RULE_SLOTS - 1; i >= 0; i--) begin
			if (hits_q[i]) begin
				idx = 4'(i);
				act = acts_q[i];
			end
		end
		rest = hits_q & (hits_q - 1'b1);
	end

	assign result_valid       = busy_q;
	assign result.hit_slot    = idx;
	assign result.action_kind = act;
	assign result.hit         = |hits_q;
	assign result.last        = (rest == '0);
	assign take               = busy_q && !result_stall;
	assign done               = take && result.last;

	// hold the emitter busy until the last result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (tail.vld) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// load the vector, drop each slot as its result is taken
	always_ff @(posedge clk) begin
		if (tail.vld) begin
			hits_q <= tail.hits;
			acts_q <= tail.acts;
		end else if (take) begin
			hits_q <= rest;
		end
	end

endmodule

// File: sv/packet_rule_classifier.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier: intrusion rule matcher
// A chain of rule cells that a packet walks through, one cell per cycle,
// followed by an emitter that reports every matching rule in slot order.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: a transaction with mode load writes one rule slot and marks
//   it valid; it yields no result. A transaction
//   with mode check sends the packet header into the rule chain.
//   result channel: one transaction per matching rule, lowest slot first,
//   with last set on the final one; a packet that matches nothing yields one
//   result with hit clear and last set.
//   Cell 0 compares a check in its accepting cycle, then the check steps
//   one cell per cycle down the registered chain; the emitter registers the
//   match vector at the chain's end and then offers the first result.
//   Results then leave at one per cycle while result_stall is low.
//   Only one check is in flight at a time: item_stall stays high from the
//   accepted check until its last result is taken, and loads are accepted
//   only while no check is in flight.
//   Reset clears all slot valid bits and the control state; rule contents
//   are undefined until loaded. While result_stall is high the pending
//   result holds, and while a check is in flight the block accepts nothing.
// ----------------------------------------------------------------------------
module packet_rule_classifier (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  prc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output prc_pkg::result_t result
);

	prc_pkg::link_t link [prc_pkg::RULE_SLOTS+1];
	logic           busy_q;
	logic           accept;
	logic           done;

	assign item_stall = busy_q;
	assign accept     = item_valid && !busy_q;

	// drive the chain head from the incoming check
	assign link[0].vld          = accept && (item.mode == prc_pkg::MODE_CHECK);
	assign link[0].probe.proto  = item.proto_code;
	assign link[0].probe.kind   = item.net_kind;
	assign link[0].probe.src_hi = item.src_addr_hi;
	assign link[0].probe.src_lo = item.src_addr_lo;
	assign link[0].probe.dst_hi = item.dst_addr_hi;
	assign link[0].probe.dst_lo = item.dst_addr_lo;
	assign link[0].probe.sport  = item.src_port_num;
	assign link[0].probe.dport  = item.dst_port_num;
	assign link[0].probe.flags  = item.tcp_flag_bits;
	assign link[0].hits         = '0;
	assign link[0].acts         = '0;

	// row of rule cells
	for (genvar i = 0; i < prc_pkg::RULE_SLOTS; i++) begin : g_cell
		logic ld_en;
		assign ld_en = accept && (item.mode == prc_pkg::MODE_LOAD) &&
			(32'(item.slot) == 32'(i));
		prc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ld_en  (ld_en),
			.ld     (item),
			.up     (link[i]),
			.dn     (link[i+1])
		);
	end

	prc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.tail         (link[prc_pkg::RULE_SLOTS]),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.done         (done)
	);

	// hold off new transactions while a check is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (link[0].vld) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

endmodule

// File: tb/packet_rule_classifier_test.sv
// ----------------------------------------------------------------------------
// packet_rule_classifier_test: self-checking bench of the rule classifier
// Loads rule slots and sends packet checks through the item channel. Each
// accepted transaction also goes to a local rule table that works out the
// hit list. Every result is compared with the oldest expected one. Both sides
// idle at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module packet_rule_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import prc_pkg::*;

	localparam logic [2:0] PROTO_ICMP  = 3'd2;
	localparam logic [2:0] PROTO_ARP   = 3'd3;
	localparam logic [2:0] PROTO_RSVD6 = 3'd6;
	localparam logic [2:0] PROTO_RSVD7 = 3'd7;
	localparam logic [1:0] KIND_OTHER  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [63:0] ONES64     = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam int RANDOM_ITEMS = 186;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// stimulus side
	item_t                 pending_items [$];
	item_t                 gen_rules [RULE_SLOTS];
	logic [RULE_SLOTS-1:0] gen_loaded = '0;
	logic [63:0]           addr_hi_pool [4];
	logic [63:0]           addr_lo_pool [4];
	logic [15:0]           port_pool [4];
	logic [7:0]            flag_pool [2];
	int                    total_items = 0;

	// rule table as seen by the checker
	rule_t   rule_table [RULE_SLOTS];
	bit      rule_loaded [RULE_SLOTS];
	result_t expected_results [$];

	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	int          error_count = 0;
	int          cycle_count = 0;
	logic        quiet_send;
	logic        quiet_recv;

	assign quiet_send = ((items_sent / 25) % 4) == 3;
	assign quiet_recv = ((results_seen / 25) % 4) == 3;

	packet_rule_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_addr(input bit upper);
		if ($urandom_range(0, 4) == 0)
			return rand64();
		return upper ? addr_hi_pool[$urandom_range(0, 3)] : addr_lo_pool[$urandom_range(0, 3)];
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom);
		return port_pool[$urandom_range(0, 3)];
	endfunction

	function automatic item_t make_item(input logic mode, input logic [3:0] slot,
		input logic [2:0] proto, input logic [1:0] kind,
		input logic [63:0] shi, slo, dhi, dlo,
		input logic [15:0] sp, dp, input logic [7:0] flags, input logic [4:0] opts);
		item_t it;
		it.mode          = mode;
		it.slot          = slot;
		it.proto_code    = proto;
		it.net_kind      = kind;
		it.src_addr_hi   = shi;
		it.src_addr_lo   = slo;
		it.dst_addr_hi   = dhi;
		it.dst_addr_lo   = dlo;
		it.src_port_num  = sp;
		it.dst_port_num  = dp;
		it.tcp_flag_bits = flags;
		it.rule_opts     = opts;
		return it;
	endfunction

	// queue a transaction and track which rules the stimulus has loaded
	function automatic void queue_item(input item_t it);
		pending_items.push_back(it);
		if (it.mode == MODE_LOAD) begin
			gen_rules[it.slot]  = it;
			gen_loaded[it.slot] = 1'b1;
		end
	endfunction

	function automatic bit addr_match(input logic any, input logic rule_v6,
		input logic [1:0] kind, input logic [63:0] rule_hi, rule_lo, pkt_hi, pkt_lo);
		if (any)
			return 1'b1;
		if (kind == KIND_V4)
			return !rule_v6 && (rule_lo[31:0] == pkt_lo[31:0]);
		if (kind == KIND_V6)
			return rule_v6 && (rule_hi == pkt_hi) && (rule_lo == pkt_lo);
		return 1'b0;
	endfunction

	function automatic bit port_match(input logic any, input logic [2:0] proto,
		input logic [15:0] rule_port, pkt_port);
		if (any)
			return 1'b1;
		if (proto == PROTO_TCP || proto == PROTO_UDP)
			return rule_port == pkt_port;
		return 1'b0;
	endfunction

	// store a loaded rule, or list every matching slot of a checked packet
	function automatic void match_rules(input item_t it);
		rule_t                 r;
		logic [RULE_SLOTS-1:0] matched;
		int                    last_slot;
		result_t               res;
		if (it.mode == MODE_LOAD) begin
			r.proto  = it.proto_code;
			r.v6     = (it.net_kind == KIND_V6);
			r.src_hi = it.src_addr_hi;
			r.src_lo = it.src_addr_lo;
			r.dst_hi = it.dst_addr_hi;
			r.dst_lo = it.dst_addr_lo;
			r.sport  = it.src_port_num;
			r.dport  = it.dst_port_num;
			r.flags  = it.tcp_flag_bits;
			r.opts   = it.rule_opts;
			rule_table[it.slot]  = r;
			rule_loaded[it.slot] = 1'b1;
			return;
		end
		matched   = '0;
		last_slot = -1;
		for (int s = 0; s < RULE_SLOTS; s++) begin
			if (rule_loaded[s]) begin
				r = rule_table[s];
				if ((r.proto == it.proto_code || r.proto == PROTO_ANY)
					&& addr_match(r.opts[OPT_SRC_ADDR_ANY], r.v6, it.net_kind,
						r.src_hi, r.src_lo, it.src_addr_hi, it.src_addr_lo)
					&& port_match(r.opts[OPT_SRC_PORT_ANY], it.proto_code,
						r.sport, it.src_port_num)
					&& addr_match(r.opts[OPT_DST_ADDR_ANY], r.v6, it.net_kind,
						r.dst_hi, r.dst_lo, it.dst_addr_hi, it.dst_addr_lo)
					&& port_match(r.opts[OPT_DST_PORT_ANY], it.proto_code,
						r.dport, it.dst_port_num)
					&& (r.flags == FLAGS_ANY
						|| (r.flags == it.tcp_flag_bits && r.proto == PROTO_TCP))) begin
					matched[s] = 1'b1;
					last_slot  = s;
				end
			end
		end
		if (last_slot < 0) begin
			res      = '0;
			res.last = 1'b1;
			expected_results.push_back(res);
		end else begin
			for (int s = 0; s <= last_slot; s++) begin
				if (matched[s]) begin
					res.hit_slot    = 4'(s);
					res.action_kind = rule_table[s].opts[OPT_ACTION_LOG];
					res.hit         = 1'b1;
					res.last        = (s == last_slot);
					expected_results.push_back(res);
				end
			end
		end
	endfunction

	// drive transactions from the pending queue with a random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			send_gap   <= 0;
			items_sent <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				match_rules(item);
				items_sent <= items_sent + 1;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap   <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items[0];
					pending_items.delete(0);
					item_valid <= 1'b1;
					send_gap   <= quiet_send ? 0 : $urandom_range(0, 9);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// hold off the result side for a long stretch, twice during the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && items_sent >= 60 + holds_done * 80) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// take results, compare them and draw the stall after each one
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int unsigned gap_next;
		result_t     want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_gap     <= 0;
			results_seen <= 0;
			error_count  <= 0;
		end else begin
			gap_next = (recv_gap != 0) ? recv_gap - 1 : 0;
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("unexpected result: slot %0d action %0d hit %0b last %0b",
							result.hit_slot, result.action_kind, result.hit, result.last);
					error_count <= error_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (result.hit_slot !== want.hit_slot
						|| result.action_kind !== want.action_kind
						|| result.hit !== want.hit
						|| result.last !== want.last) begin
						if (error_count < MAX_REPORTS)
							$display({"result mismatch: expected slot %0d action %0d hit %0b",
								" last %0b, got slot %0d action %0d hit %0b last %0b"},
								want.hit_slot, want.action_kind, want.hit, want.last,
								result.hit_slot, result.action_kind, result.hit, result.last);
						error_count <= error_count + 1;
					end
				end
				gap_next = quiet_recv ? 0 : $urandom_range(0, 9);
			end
			recv_gap     <= gap_next;
			result_stall <= (gap_next != 0) || (hold_left != 0);
		end
	end

	// stop a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		item_t it;
		int    pick;
		int    roll;
		int    src_slot;

		for (int i = 0; i < 4; i++) begin
			addr_hi_pool[i] = rand64();
			addr_lo_pool[i] = rand64();
			port_pool[i]    = 16'($urandom);
		end
		port_pool[0] = 16'hFFFF;
		port_pool[1] = 16'h0000;
		flag_pool[0] = 8'h02;
		flag_pool[1] = 8'h12;

		// directed: empty table, then exact v4, wildcard, v6, reserved codes
		queue_item(make_item(MODE_CHECK, 4'd9, PROTO_TCP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'd0));
		queue_item(make_item(MODE_LOAD, 4'd15, PROTO_TCP, KIND_V4, ONES64,
			64'hDEAD_BEEF_0A00_0001, '0, 64'h0000_0000_C0A8_0101,
			16'hFFFF, 16'd443, 8'h12, 5'b00000));
		queue_item(make_item(MODE_LOAD, 4'd0, PROTO_ANY, KIND_OTHER, '0, '0, '0, '0,
			16'd0, 16'd0, FLAGS_ANY, 5'b11111));
		// v4 compares the low 32 bits only
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_TCP, KIND_V4, '0,
			64'h1234_5678_0A00_0001, ONES64, 64'hFFFF_FFFF_C0A8_0101,
			16'hFFFF, 16'd443, 8'h12, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_TCP, KIND_V4, '0,
			64'h1234_5678_0A00_0001, ONES64, 64'hFFFF_FFFF_C0A8_0101,
			16'hFFFF, 16'd443, 8'h13, 5'b11111));
		queue_item(make_item(MODE_CHECK, 4'd15, PROTO_TCP, KIND_V4, '0,
			64'h1234_5678_0A00_0001, ONES64, 64'hFFFF_FFFF_C0A8_0101,
			16'hFFFF, 16'd444, 8'h12, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd3, PROTO_ICMP, KIND_UNUSED, ONES64, ONES64,
			ONES64, ONES64, 16'hFFFF, 16'hFFFF, 8'hFF, 5'b11111));
		queue_item(make_item(MODE_LOAD, 4'd7, PROTO_UDP, KIND_V6, ONES64, ONES64,
			ONES64, ONES64, 16'hFFFF, 16'd0, FLAGS_ANY, 5'b10000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_UDP, KIND_V6, ONES64, ONES64,
			ONES64, ONES64, 16'hFFFF, 16'd0, 8'h00, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_UDP, KIND_V6, 64'h7FFF_FFFF_FFFF_FFFF,
			ONES64, ONES64, ONES64, 16'hFFFF, 16'd0, 8'h00, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_UDP, KIND_V4, ONES64, ONES64,
			ONES64, ONES64, 16'hFFFF, 16'd0, 8'h00, 5'b00000));
		queue_item(make_item(MODE_LOAD, 4'd3, PROTO_RSVD7, KIND_UNUSED, '0, '0, '0, '0,
			16'd0, 16'd0, FLAGS_ANY, 5'b01111));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_RSVD7, KIND_OTHER, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_RSVD6, KIND_OTHER, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));
		// flags other than any need a TCP rule
		queue_item(make_item(MODE_LOAD, 4'd4, PROTO_UDP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b01111));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_UDP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));
		// exact ports need a TCP or UDP packet
		queue_item(make_item(MODE_LOAD, 4'd5, PROTO_ICMP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, FLAGS_ANY, 5'b00101));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_ICMP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));
		// replace the catch-all rule
		queue_item(make_item(MODE_LOAD, 4'd0, PROTO_TCP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, FLAGS_ANY, 5'b01010));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_ARP, KIND_OTHER, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_TCP, KIND_V4, '0, '0, '0, '0,
			16'd5, 16'd6, 8'h00, 5'b00000));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_TCP, KIND_V6, '0, '0, '0, '0,
			16'd5, 16'd6, 8'h00, 5'b00000));
		queue_item(make_item(MODE_LOAD, 4'd9, PROTO_TCP, KIND_V6, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b01111));
		queue_item(make_item(MODE_CHECK, 4'd0, PROTO_TCP, KIND_V4, '0, '0, '0, '0,
			16'd0, 16'd0, 8'h00, 5'b00000));

		// random: rule loads, packets built from loaded rules, and noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25 || gen_loaded == '0) begin
				it.mode = MODE_LOAD;
				it.slot = 4'($urandom_range(0, RULE_SLOTS - 1));
				roll = $urandom_range(0, 9);
				it.proto_code = (roll < 3) ? PROTO_ANY :
					(roll < 9) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
				roll = $urandom_range(0, 9);
				it.net_kind = (roll < 9) ? ($urandom_range(0, 1) ? KIND_V6 : KIND_V4) :
					2'($urandom_range(0, 3));
				it.src_addr_hi  = pick_addr(1'b1);
				it.src_addr_lo  = pick_addr(1'b0);
				it.dst_addr_hi  = pick_addr(1'b1);
				it.dst_addr_lo  = pick_addr(1'b0);
				it.src_port_num = pick_port();
				it.dst_port_num = pick_port();
				roll = $urandom_range(0, 3);
				it.tcp_flag_bits = (roll < 2) ? FLAGS_ANY :
					(roll == 2) ? flag_pool[$urandom_range(0, 1)] : 8'($urandom);
				it.rule_opts = 5'($urandom_range(0, 31));
				// make some rules catch everything so packets hit many slots
				if ($urandom_range(0, 4) == 0) begin
					it.rule_opts[3:0] = 4'hF;
					it.proto_code     = PROTO_ANY;
					it.tcp_flag_bits  = FLAGS_ANY;
				end
			end else if (pick < 85) begin
				do
					src_slot = $urandom_range(0, RULE_SLOTS - 1);
				while (!gen_loaded[src_slot]);
				it      = gen_rules[src_slot];
				it.mode = MODE_CHECK;
				it.slot = 4'($urandom_range(0, 15));
				if (it.proto_code == PROTO_ANY)
					it.proto_code = 3'($urandom_range(0, 3));
				it.net_kind = (it.net_kind == KIND_V6) ? KIND_V6 : KIND_V4;
				if (it.net_kind == KIND_V4) begin
					it.src_addr_hi        = rand64();
					it.dst_addr_hi        = rand64();
					it.src_addr_lo[63:32] = $urandom;
					it.dst_addr_lo[63:32] = $urandom;
				end
				if (it.tcp_flag_bits == FLAGS_ANY)
					it.tcp_flag_bits = 8'($urandom);
				it.rule_opts = 5'($urandom_range(0, 31));
				// break one field now and then
				if ($urandom_range(0, 9) < 3) begin
					case ($urandom_range(0, 5))
						0: it.proto_code = 3'($urandom_range(0, 7));
						1: it.net_kind = 2'($urandom_range(0, 3));
						2: it.src_addr_lo = pick_addr(1'b0);
						3: it.dst_addr_hi = pick_addr(1'b1);
						4: it.src_port_num = pick_port();
						default: it.tcp_flag_bits = 8'($urandom);
					endcase
				end
			end else begin
				it = make_item(MODE_CHECK, 4'($urandom_range(0, 15)),
					3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					rand64(), rand64(), rand64(), rand64(),
					16'($urandom), 16'($urandom), 8'($urandom),
					5'($urandom_range(0, 31)));
			end
			queue_item(it);
		end
		total_items = pending_items.size();

		// hold reset low, then release it
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all sent, all results back, then a quiet tail
		wait (items_sent == total_items);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
